FILE: design/assert_macros.svh
// Assertion macros shared by the keyed table engine RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define KTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define KTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/kte_pkg.sv
// Package for the keyed table engine: sizes, operation codes, item structs
// and the command and status bundles between controller and datapath. No dependencies.
package kte_pkg;

    localparam int TABLE_DEPTH  = 128;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS   = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_CHANGE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] key;
        logic [31:0]        payload;
    } req_t;

    typedef struct packed {
        logic        success;
        logic [31:0] found_payload;
        logic [7:0]  row_count;
        logic        table_full;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic add;
        logic clear;
        logic scan;
        logic find_hit;
        logic change_hit;
        logic remove_hit;
        logic shift;
        logic publish;
    } kte_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       hit;
        logic       pipe_valid;
        logic       more_scan;
        logic       more_shift;
    } kte_status_t;

endpackage

FILE: design/kte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the key and data columns of the table.
module kte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/kte_datapath.sv
// Datapath of the keyed table engine: request and count registers, scan pointer,
// key and data RAMs, compare and result register. Depends on kte_pkg and kte_ram.
module kte_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  kte_pkg::req_t       req,
    input  kte_pkg::kte_cmd_t   cmd,
    output kte_pkg::kte_status_t status,
    output kte_pkg::rsp_t       rsp
);
    import kte_pkg::*;

    req_t                  req_reg, req_next;
    rsp_t                  rsp_reg, rsp_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_BITS-1:0]   pipe_idx_reg, pipe_idx_next;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic                  ok_reg, ok_next;
    logic [31:0]           found_reg, found_next;

    logic                    key_we;
    logic                    pay_we;
    logic [IDX_BITS-1:0]     wr_addr;
    logic [31:0]             key_wdata;
    logic [PAYLOAD_BITS-1:0] pay_wdata;
    logic [31:0]             key_rdata;
    logic [PAYLOAD_BITS-1:0] pay_rdata;
    logic                    issue;

    logic [PAYLOAD_BITS+31:0] req_pay_wide;
    logic [PAYLOAD_BITS+31:0] rd_pay_wide;
    logic [COUNT_BITS+7:0]    count_wide;
    logic                     more_scan;
    logic                     more_shift;
    logic                     hit;

    assign req_pay_wide = {{PAYLOAD_BITS{1'b0}}, req_reg.payload};
    assign rd_pay_wide  = {32'b0, pay_rdata};
    assign count_wide   = {8'b0, count_reg};
    assign more_scan    = scan_idx_reg < count_reg;
    assign more_shift   = scan_idx_reg <= count_reg;
    assign hit          = pipe_valid_reg && (key_rdata == req_reg.key);

    assign status.op         = req_reg.operation;
    assign status.hit        = hit;
    assign status.pipe_valid = pipe_valid_reg;
    assign status.more_scan  = more_scan;
    assign status.more_shift = more_shift;

    kte_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_key_ram (
        .clk  (clk),
        .we   (key_we),
        .waddr(wr_addr),
        .wdata(key_wdata),
        .raddr(scan_idx_reg[IDX_BITS-1:0]),
        .rdata(key_rdata)
    );

    kte_ram #(
        .WIDTH(PAYLOAD_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_pay_ram (
        .clk  (clk),
        .we   (pay_we),
        .waddr(wr_addr),
        .wdata(pay_wdata),
        .raddr(scan_idx_reg[IDX_BITS-1:0]),
        .rdata(pay_rdata)
    );

    always_comb
    begin
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        pipe_idx_next   = pipe_idx_reg;
        pipe_valid_next = pipe_valid_reg;
        ok_next         = ok_reg;
        found_next      = found_reg;
        key_we          = 1'b0;
        pay_we          = 1'b0;
        wr_addr         = count_reg[IDX_BITS-1:0];
        key_wdata       = req_reg.key;
        pay_wdata       = req_pay_wide[PAYLOAD_BITS-1:0];
        issue           = 1'b0;

        if (cmd.load)
        begin
            req_next        = req;
            scan_idx_next   = '0;
            pipe_valid_next = 1'b0;
            ok_next         = 1'b0;
            found_next      = '0;
        end

        if (cmd.add && (count_reg < COUNT_BITS'(TABLE_DEPTH)))
        begin
            key_we     = 1'b1;
            pay_we     = 1'b1;
            count_next = count_reg + COUNT_BITS'(1);
            ok_next    = 1'b1;
        end

        if (cmd.clear)
        begin
            count_next = '0;
            ok_next    = 1'b1;
        end

        if (cmd.scan || cmd.shift)
        begin
            issue           = cmd.scan ? more_scan : more_shift;
            scan_idx_next   = scan_idx_reg + COUNT_BITS'(issue);
            pipe_valid_next = issue;
            pipe_idx_next   = scan_idx_reg[IDX_BITS-1:0];
        end

        if (cmd.shift && pipe_valid_reg)
        begin
            key_we    = 1'b1;
            pay_we    = 1'b1;
            wr_addr   = pipe_idx_reg - IDX_BITS'(1);
            key_wdata = key_rdata;
            pay_wdata = pay_rdata;
        end

        if (cmd.find_hit)
        begin
            found_next = rd_pay_wide[31:0];
            ok_next    = 1'b1;
        end

        if (cmd.change_hit)
        begin
            pay_we  = 1'b1;
            wr_addr = pipe_idx_reg;
            ok_next = 1'b1;
        end

        if (cmd.remove_hit)
        begin
            count_next      = count_reg - COUNT_BITS'(1);
            scan_idx_next   = COUNT_BITS'(pipe_idx_reg) + COUNT_BITS'(1);
            pipe_valid_next = 1'b0;
            ok_next         = 1'b1;
        end

        if (cmd.publish)
        begin
            rsp_next.success       = ok_reg;
            rsp_next.found_payload = found_reg;
            rsp_next.row_count     = count_wide[7:0];
            rsp_next.table_full    = count_reg == COUNT_BITS'(TABLE_DEPTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
        scan_idx_reg <= scan_idx_next;
        pipe_idx_reg <= pipe_idx_next;
        ok_reg       <= ok_next;
        found_reg    <= found_next;
    end

    assign rsp = rsp_reg;

endmodule

FILE: design/kte_ctrl.sv
// Controller of the keyed table engine: request sequencing and result handshake.
// Depends on kte_pkg for the command and status bundles and the operation codes.
module kte_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  kte_pkg::kte_status_t status,
    output kte_pkg::kte_cmd_t    cmd
);
    import kte_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (status.op == OP_ADD)
                begin
                    cmd.add    = 1'b1;
                    state_next = S_FINISH;
                end
                else if (status.op == OP_CLEAR)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_FINISH;
                end
                else if ((status.op == OP_REMOVE) || (status.op == OP_FIND) ||
                         (status.op == OP_CHANGE))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                priority if (status.hit)
                begin
                    priority if (status.op == OP_FIND)
                    begin
                        cmd.find_hit = 1'b1;
                        state_next   = S_FINISH;
                    end
                    else if (status.op == OP_CHANGE)
                    begin
                        cmd.change_hit = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        cmd.remove_hit = 1'b1;
                        state_next     = S_SHIFT;
                    end
                end
                else if (!status.pipe_valid && !status.more_scan)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (!status.pipe_valid && !status.more_shift)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;

endmodule

FILE: design/keyed_table_engine.sv
// Top level of the keyed table engine: controller, datapath and assertions.
// Depends on kte_pkg, kte_ctrl, kte_datapath, kte_ram and assert_macros.svh.
//
//   channel | signals                     | carries
//   request | req_valid, req_ready, req   | operation, key, payload
//   result  | rsp_valid, rsp_ready, rsp   | success, found_payload, row_count, table_full
//
// Add, clear and unknown operations go from acceptance through the dispatch and finish states.
// Find and change scan up to the N rows held, remove also shifts the later rows down,
// through the single read port of the key and data RAMs, one row per cycle.
// Reset empties the table at once; row contents are not cleared.
// A new request is taken while an earlier result still waits; a stalled result
// holds the engine in its final state until the result register frees.
`include "assert_macros.svh"

module keyed_table_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  kte_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output kte_pkg::rsp_t rsp
);
    import kte_pkg::*;

    kte_cmd_t    cmd;
    kte_status_t status;

    kte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status   (status),
        .cmd      (cmd)
    );

    kte_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .status(status),
        .rsp   (rsp)
    );

    `KTE_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0(cmd), "controller issued two commands")
    `KTE_ASSERT_NEXT(a_publish_valid, cmd.publish, rsp_valid, "result published without valid")
    `KTE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
        "engine took a request without leaving idle")
    `KTE_ASSERT_NOW(a_miss_zero_data, rsp_valid && !rsp.success, rsp.found_payload == 32'd0,
        "failed request returned data")

endmodule
